>>> design/jsfd_pkg.sv
// Shared constants for the joint-state frame deframer.
// Used by jsfd_check, jsfd_emit and the top level; depends on nothing.

package jsfd_pkg;

  localparam int JOINTS_DEF = 6;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;
  localparam int JIDX_W = 4;

  localparam logic [BYTE_W-1:0] HDR0     = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR1     = 8'h55;
  localparam logic [BYTE_W-1:0] STATE_ID = 8'h11;

endpackage

>>> design/jsfd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.

module jsfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 52
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/jsfd_check.sv
// Input side of the deframer: takes byte beats, keeps the window in a ring of
// per-byte check entries and assembled words, and detects complete frames.
// Depends on jsfd_pkg and jsfd_ram.

module jsfd_check #(
  parameter int JOINTS = jsfd_pkg::JOINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [7:0]                             in_tdata,
  input  logic [0:0]                             in_tuser,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic                                   hold,
  output logic                                   word_we,
  output logic [$clog2(8*JOINTS+4)-1:0]          word_waddr,
  output logic [jsfd_pkg::WORD_W-1:0]            word_wdata,
  output logic                                   start,
  output logic [$clog2(8*JOINTS+4)-1:0]          start_addr
);

  localparam int FRAME_LEN = 8 * JOINTS + 4;
  localparam int AW = $clog2(FRAME_LEN);
  localparam logic [AW:0]   LEN_W  = (AW+1)'(FRAME_LEN);
  localparam logic [AW-1:0] LAST_A = AW'(FRAME_LEN - 1);

  typedef struct packed {
    logic                          hdr_ok;
    logic [jsfd_pkg::BYTE_W-1:0]   pxor;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [7:0]    px_r, px_nxt;
  logic [7:0]    b1_r, b2_r, b3_r;
  logic          accept, flush, wr, chk, good;
  logic [7:0]    rx_byte, px_new;
  logic [AW:0]   rd_sum, st_sum;
  logic [AW-1:0] meta_raddr;
  meta_t         meta_w, meta_q;
  logic [META_W-1:0] meta_q_bits;

  assign rx_byte   = in_tdata;
  assign flush     = in_tuser[0];
  assign in_tready = !hold;
  assign accept    = in_tvalid && in_tready;
  assign wr        = accept && !flush;

  assign px_new = px_r ^ rx_byte;
  assign meta_q = meta_t'(meta_q_bits);
  assign chk    = wr && (fill_r == LAST_A);
  assign good   = chk && meta_q.hdr_ok && (meta_q.pxor == px_new);

  assign meta_w.hdr_ok = (b2_r == jsfd_pkg::HDR0) && (b1_r == jsfd_pkg::HDR1) &&
                         (rx_byte == jsfd_pkg::STATE_ID);
  assign meta_w.pxor   = px_r;

  always_comb begin
    wp_nxt = wp_r;
    if (wr) begin
      wp_nxt = (wp_r == LAST_A) ? '0 : wp_r + AW'(1);
    end
    rd_sum = {1'b0, wp_nxt} + (AW+1)'(3);
    meta_raddr = (rd_sum >= LEN_W) ? AW'(rd_sum - LEN_W) : rd_sum[AW-1:0];
    st_sum = {1'b0, wp_r} + (AW+1)'(7);
    start_addr = (st_sum >= LEN_W) ? AW'(st_sum - LEN_W) : st_sum[AW-1:0];
  end

  always_comb begin
    fill_nxt = fill_r;
    px_nxt   = px_r;
    if (accept && flush) begin
      fill_nxt = '0;
      px_nxt   = '0;
    end else if (wr) begin
      if (good) begin
        fill_nxt = '0;
        px_nxt   = '0;
      end else begin
        fill_nxt = chk ? fill_r : fill_r + AW'(1);
        px_nxt   = px_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      px_r   <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      px_r   <= px_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      b1_r <= rx_byte;
      b2_r <= b1_r;
      b3_r <= b2_r;
    end
  end

  // Each entry holds the header match for the byte two places older and the
  // running XOR up to the byte one place older.
  jsfd_ram #(
    .WIDTH (META_W),
    .DEPTH (FRAME_LEN)
  ) u_meta_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (wp_r),
    .wdata (meta_w),
    .re    (1'b1),
    .raddr (meta_raddr),
    .rdata (meta_q_bits)
  );

  assign word_we    = wr;
  assign word_waddr = wp_r;
  assign word_wdata = {rx_byte, b1_r, b2_r, b3_r};
  assign start      = good;

endmodule

>>> design/jsfd_emit.sv
// Output side of the deframer: reads the words of a checked frame from the word
// memory, one per beat, and holds input when writes would catch up with reads.
// Depends on jsfd_pkg.

module jsfd_emit #(
  parameter int JOINTS = jsfd_pkg::JOINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [$clog2(8*JOINTS+4)-1:0]         start_addr,
  input  logic                                  byte_wr,
  output logic                                  hold,
  output logic                                  word_re,
  output logic [$clog2(8*JOINTS+4)-1:0]         word_raddr,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [jsfd_pkg::JIDX_W:0]             out_tuser,
  output logic                                  out_tlast
);

  localparam int FRAME_LEN = 8 * JOINTS + 4;
  localparam int AW = $clog2(FRAME_LEN);
  localparam int NW = $clog2(2 * JOINTS + 1);
  localparam int CW = $clog2(FRAME_LEN + 8);
  localparam logic [AW:0]   LEN_W  = (AW+1)'(FRAME_LEN);
  localparam logic [NW-1:0] J_N    = NW'(JOINTS);
  localparam logic [NW-1:0] LAST_N = NW'(2 * JOINTS - 1);

  logic                          busy_r, rd_v_r;
  logic [AW-1:0]                 ep_r;
  logic [NW-1:0]                 n_r;
  logic [AW-1:0]                 kcnt_r;
  logic [jsfd_pkg::JIDX_W-1:0]   jidx_r;
  logic                          vel_r, last_r;
  logic                          adv, issue, vel;
  logic [NW-1:0]                 joint;
  logic [AW:0]                   ep_sum;
  logic [AW-1:0]                 ep_inc;
  logic [CW-1:0]                 wr_next, rd_low;

  assign adv   = !rd_v_r || out_tready;
  assign issue = busy_r && adv;

  assign vel   = (n_r >= J_N);
  assign joint = vel ? n_r - J_N : n_r;

  assign ep_sum = {1'b0, ep_r} + (AW+1)'(4);
  assign ep_inc = (ep_sum >= LEN_W) ? AW'(ep_sum - LEN_W) : ep_sum[AW-1:0];

  // The next byte lands kcnt+1 places after the frame's final byte; the oldest
  // unread word lies 7+4n places after it.
  assign wr_next = CW'(kcnt_r) + CW'(1);
  assign rd_low  = (CW'(n_r) << 2) + CW'(7);
  assign hold    = busy_r && !(wr_next < rd_low);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rd_v_r <= 1'b0;
      n_r    <= '0;
      kcnt_r <= '0;
      ep_r   <= '0;
    end else begin
      if (adv) begin
        rd_v_r <= issue;
      end
      if (start) begin
        busy_r <= 1'b1;
        ep_r   <= start_addr;
        n_r    <= '0;
        kcnt_r <= '0;
      end else begin
        if (busy_r && byte_wr) begin
          kcnt_r <= kcnt_r + AW'(1);
        end
        if (issue) begin
          ep_r <= ep_inc;
          n_r  <= n_r + NW'(1);
          if (n_r == LAST_N) begin
            busy_r <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      jidx_r <= jsfd_pkg::JIDX_W'(joint);
      vel_r  <= vel;
      last_r <= (n_r == LAST_N);
    end
  end

  assign word_re    = issue;
  assign word_raddr = ep_r;
  assign out_tvalid = rd_v_r;
  assign out_tuser  = {vel_r, jidx_r};
  assign out_tlast  = last_r;

endmodule

>>> design/joint_state_frame_deframer_top.sv
// Top level of the joint-state frame deframer.
// Depends on jsfd_pkg, jsfd_ram, jsfd_check and jsfd_emit.

// The block takes one received byte per beat, one beat per cycle while
// in_tready is high, and looks for frames of 8*JOINTS+4 bytes: 0xAA 0x55, id
// 0x11, the payload and an XOR checksum over id and payload. A byte that
// completes a good frame starts a burst of 2*JOINTS 32-bit words, all
// positions and then all velocities, one word per cycle while out_tready is
// high, the last one marked with tlast. Input keeps flowing during the burst.
// If the output side stalls long enough that new bytes would overwrite words
// not yet read out of the word memory, in_tready drops until reads move on.
// State lives in two memories of 8*JOINTS+4 entries (per-byte check data and
// assembled words) and needs no clearing after reset. A beat with in_tuser
// set empties the window and its data is ignored.

module joint_state_frame_deframer_top #(
  parameter int JOINTS = jsfd_pkg::JOINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   in_tdata,   // rx_byte[7:0]
  input  logic [0:0]                   in_tuser,   // flush[0]
  input  logic                         in_tvalid,
  output logic                         in_tready,
  output logic [31:0]                  out_tdata,  // word_value[31:0]
  output logic [4:0]                   out_tuser,  // joint_index[3:0], is_velocity[4]
  output logic                         out_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready
);

  localparam int FRAME_LEN = 8 * JOINTS + 4;
  localparam int AW = $clog2(FRAME_LEN);

  logic                          hold, start, word_we, word_re;
  logic [AW-1:0]                 start_addr, word_waddr, word_raddr;
  logic [jsfd_pkg::WORD_W-1:0]   word_wdata, word_q;

  jsfd_check #(
    .JOINTS (JOINTS)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .hold       (hold),
    .word_we    (word_we),
    .word_waddr (word_waddr),
    .word_wdata (word_wdata),
    .start      (start),
    .start_addr (start_addr)
  );

  jsfd_ram #(
    .WIDTH (jsfd_pkg::WORD_W),
    .DEPTH (FRAME_LEN)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .re    (word_re),
    .raddr (word_raddr),
    .rdata (word_q)
  );

  jsfd_emit #(
    .JOINTS (JOINTS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_addr (start_addr),
    .byte_wr    (word_we),
    .hold       (hold),
    .word_re    (word_re),
    .word_raddr (word_raddr),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = word_q;

endmodule
